// ===== hdl/assert_macros.svh =====
// Assertion macros for the cube case polygon triangulator.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CCT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("triangulator check failed");
`define CCT_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("triangulator forbidden condition seen");
`else
`define CCT_ASSERT(lbl, clk, rstn, prop)
`define CCT_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ===== hdl/cct_pkg.sv =====
// Package for the cube case polygon triangulator: types, cube tables, states.
// No dependencies; used by the front, queue, back, top level and testbench.
`timescale 1ns / 1ps
package cct_pkg;

  localparam int NumEdges = 12;
  localparam int QueueDepth = 2;

  typedef logic [3:0] edge_t;
  typedef logic [2:0] face_t;
  typedef logic [2:0] corner_t;

  // Cube edge end corners.
  localparam corner_t EDGE_C1 [NumEdges] = '{3'd0, 3'd2, 3'd0, 3'd1, 3'd4, 3'd6,
                                              3'd4, 3'd5, 3'd0, 3'd1, 3'd2, 3'd3};
  localparam corner_t EDGE_C2 [NumEdges] = '{3'd1, 3'd3, 3'd2, 3'd3, 3'd5, 3'd7,
                                              3'd6, 3'd7, 3'd4, 3'd5, 3'd6, 3'd7};
  // Faces on either side of each edge: 0 L, 1 R, 2 B, 3 T, 4 N, 5 F.
  localparam face_t FACE_LEFT [NumEdges] = '{3'd2, 3'd0, 3'd0, 3'd5, 3'd1, 3'd3,
                                              3'd4, 3'd1, 3'd4, 3'd2, 3'd3, 3'd5};
  localparam face_t FACE_RIGHT [NumEdges] = '{3'd0, 3'd3, 3'd4, 3'd0, 3'd2, 3'd1,
                                               3'd1, 3'd5, 3'd2, 3'd5, 3'd4, 3'd3};
  // Clockwise successor of each edge, on its reference face and on the other.
  localparam face_t CW_FACE [NumEdges] = '{3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1,
                                            3'd1, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3};
  localparam edge_t CW_ON [NumEdges] = '{4'd3, 4'd2, 4'd0, 4'd1, 4'd6, 4'd7,
                                          4'd5, 4'd4, 4'd4, 4'd0, 4'd1, 4'd5};
  localparam edge_t CW_OFF [NumEdges] = '{4'd8, 4'd11, 4'd10, 4'd9, 4'd9, 4'd10,
                                           4'd8, 4'd11, 4'd2, 4'd7, 4'd6, 4'd3};

  // One classified cube as it travels from the front to the back.
  typedef struct packed {
    logic [7:0]           signs;
    logic [NumEdges-1:0]  crossed;
    logic                 uniform;
  } cct_item_t;

  // Back end sequencer states.
  typedef enum logic [2:0] {
    B_IDLE,
    B_SCAN,
    B_WALK,
    B_EMIT,
    B_EMPTY
  } back_state_e;

  // Next clockwise edge from an edge on a given face.
  function automatic edge_t next_cw(edge_t e, face_t f);
    return (f == CW_FACE[e]) ? CW_ON[e] : CW_OFF[e];
  endfunction

  // Face on the far side of an edge.
  function automatic face_t other_face(edge_t e, face_t f);
    return (f == FACE_LEFT[e]) ? FACE_RIGHT[e] : FACE_LEFT[e];
  endfunction

endpackage

// ===== hdl/cct_in_if.sv =====
// Input channel of the triangulator: valid, ready and the corner signs.
// Stand-alone interface; no dependencies.
`timescale 1ns / 1ps
interface cct_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] corner_signs;

  modport source (output valid, output corner_signs, input ready);
  modport sink (input valid, input corner_signs, output ready);
endinterface

// ===== hdl/cct_out_if.sv =====
// Output channel of the triangulator: valid, ready and one triangle.
// Stand-alone interface; no dependencies.
`timescale 1ns / 1ps
interface cct_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] edge_first;
  logic [3:0] edge_prev;
  logic [3:0] edge_cur;
  logic       is_empty;
  logic       last;

  modport source (output valid, output edge_first, output edge_prev, output edge_cur,
                  output is_empty, output last, input ready);
  modport sink (input valid, input edge_first, input edge_prev, input edge_cur,
                input is_empty, input last, output ready);
endinterface

// ===== hdl/cct_front.sv =====
// Front end: accepts cube transactions, finds crossed edges and registers them.
// Depends on cct_pkg and cct_in_if.
`timescale 1ns / 1ps
module cct_front import cct_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  cct_in_if.sink     in_i,
  output logic       item_valid_o,
  input  logic       item_ready_i,
  output cct_item_t  item_o
);

  logic      valid_q;
  cct_item_t item_q;
  cct_item_t item_d;

  // An edge is crossed when its end corners differ in sign.
  always_comb begin
    item_d.signs = in_i.corner_signs;
    for (int e = 0; e < NumEdges; e++) begin
      item_d.crossed[e] = in_i.corner_signs[EDGE_C1[e]] ^ in_i.corner_signs[EDGE_C2[e]];
    end
    item_d.uniform = (item_d.crossed == '0);
  end

  assign in_i.ready = !valid_q || item_ready_i;

  // Stage register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ===== hdl/cct_queue.sv =====
// Short queue between the front and back ends of the triangulator.
// Depends on cct_pkg.
`timescale 1ns / 1ps
module cct_queue import cct_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_valid_i,
  output logic       push_ready_o,
  input  cct_item_t  push_item_i,
  output logic       pop_valid_o,
  input  logic       pop_ready_i,
  output cct_item_t  pop_item_o,
  output logic [1:0] count_o
);

  cct_item_t  mem_q [QueueDepth];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push;
  logic       do_pop;

  assign push_ready_o = (count_q != 2'(QueueDepth));
  assign pop_valid_o  = (count_q != 2'd0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign count_o      = count_q;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop) rd_ptr_q <= !rd_ptr_q;
      count_q <= count_q + 2'(do_push) - 2'(do_pop);
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== hdl/cct_back.sv =====
// Back end: walks the cube faces one step a cycle, stores the polygon edges,
// then fans them out as triangles. Depends on cct_pkg and cct_out_if.
`timescale 1ns / 1ps
module cct_back import cct_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       item_valid_i,
  output logic       item_ready_o,
  input  cct_item_t  item_i,
  cct_out_if.source  out_o
);

  back_state_e state_q, state_d;

  logic [7:0]          signs_q;
  logic [NumEdges-1:0] crossed_q;
  logic [NumEdges-1:0] done_q;
  edge_t               e_q;
  edge_t               edge_q;
  face_t               face_q;
  logic [5:0]          steps_q;
  edge_t               buf_q [NumEdges];
  logic [NumEdges-1:0] head_q;
  logic [3:0]          n_q;
  logic [3:0]          k_q;
  logic [3:0]          npoly_q;
  edge_t               apex_q;
  edge_t               prev_q;
  logic [1:0]          cnt_q;

  logic  ov_q;
  edge_t o_first_q, o_prev_q, o_cur_q;
  logic  o_empty_q, o_last_q;

  logic  out_free;
  logic  take;
  logic  scan_end, scan_start;
  edge_t nxt;
  logic  nxt_crossed;
  logic  walk_end;
  edge_t rd_edge;
  logic  rd_head;
  logic  emit_tri;
  logic  start_s1;

  assign out_free = !ov_q || out_o.ready;

  // Walk and scan decode.
  always_comb begin
    nxt         = next_cw(edge_q, face_q);
    nxt_crossed = crossed_q[nxt];
    walk_end    = (nxt_crossed && (nxt == e_q)) || (steps_q == 6'd63);
    scan_end    = (e_q == 4'(NumEdges));
    scan_start  = !scan_end && !done_q[e_q] && crossed_q[e_q] &&
                  (npoly_q != 4'(NumEdges));
    start_s1    = signs_q[EDGE_C1[e_q]];
    rd_edge     = buf_q[k_q];
    rd_head     = head_q[k_q];
    emit_tri    = !rd_head && (cnt_q == 2'd2);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (item_valid_i) state_d = item_i.uniform ? B_EMPTY : B_SCAN;
      end
      B_SCAN: begin
        if (scan_end) state_d = (n_q == 4'd0) ? B_EMPTY : B_EMIT;
        else if (scan_start) state_d = B_WALK;
      end
      B_WALK: begin
        if (walk_end) state_d = B_SCAN;
      end
      B_EMIT: begin
        if (out_free && (k_q == 4'd0)) state_d = B_IDLE;
      end
      B_EMPTY: begin
        if (out_free) state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    item_ready_o = (state_q == B_IDLE);
    take         = item_ready_o && item_valid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_o.ready) ov_q <= 1'b0;
      if (state_q == B_EMPTY && out_free) ov_q <= 1'b1;
      if (state_q == B_EMIT && out_free && emit_tri) ov_q <= 1'b1;
    end
  end

  // Datapath: walk registers, edge buffer and output register.
  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        if (take) begin
          signs_q   <= item_i.signs;
          crossed_q <= item_i.crossed;
          done_q    <= '0;
          e_q       <= 4'd0;
          n_q       <= 4'd0;
          npoly_q   <= 4'd0;
        end
      end
      B_SCAN: begin
        if (scan_end) begin
          k_q   <= n_q - 4'd1;
          cnt_q <= 2'd0;
        end else if (scan_start) begin
          edge_q  <= e_q;
          face_q  <= start_s1 ? FACE_RIGHT[e_q] : FACE_LEFT[e_q];
          steps_q <= 6'd0;
        end else begin
          e_q <= e_q + 4'd1;
        end
      end
      B_WALK: begin
        done_q[nxt] <= 1'b1;
        steps_q     <= steps_q + 6'd1;
        edge_q      <= nxt;
        if (nxt_crossed && (n_q != 4'(NumEdges))) begin
          buf_q[n_q[3:0]]  <= nxt;
          head_q[n_q]      <= (nxt == e_q);
          n_q              <= n_q + 4'd1;
        end
        if (walk_end) begin
          npoly_q <= npoly_q + 4'd1;
          e_q     <= e_q + 4'd1;
        end else if (nxt_crossed) begin
          face_q <= other_face(nxt, face_q);
        end
      end
      B_EMIT: begin
        if (out_free) begin
          if (rd_head) begin
            apex_q <= rd_edge;
            cnt_q  <= 2'd1;
          end else if (cnt_q == 2'd1) begin
            prev_q <= rd_edge;
            cnt_q  <= 2'd2;
          end else begin
            prev_q    <= rd_edge;
            o_first_q <= apex_q;
            o_prev_q  <= prev_q;
            o_cur_q   <= rd_edge;
            o_empty_q <= 1'b0;
            o_last_q  <= (k_q == 4'd0);
          end
          if (k_q != 4'd0) k_q <= k_q - 4'd1;
        end
      end
      B_EMPTY: begin
        if (out_free) begin
          o_first_q <= 4'd0;
          o_prev_q  <= 4'd0;
          o_cur_q   <= 4'd0;
          o_empty_q <= 1'b1;
          o_last_q  <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid      = ov_q;
  assign out_o.edge_first = o_first_q;
  assign out_o.edge_prev  = o_prev_q;
  assign out_o.edge_cur   = o_cur_q;
  assign out_o.is_empty   = o_empty_q;
  assign out_o.last       = o_last_q;

endmodule

// ===== hdl/cube_case_polygon_triangulator_top.sv =====
// Triangulates one lattice cube per transaction from its eight corner signs:
// a front stage finds the crossed edges, a two-entry queue decouples it, and a
// back sequencer walks the faces one step per clock and emits one triangle per
// output transaction. A cube is registered in the front stage and in the queue
// before the back end takes it; there its edges are scanned, each polygon is
// walked and the 3 to 12 stored polygon edges are fanned out while the output
// is free. Uniform cubes go from the idle state to the empty state, which
// registers their empty result once the output is free.
// Depends on cct_pkg, cct_in_if, cct_out_if, the three submodules and macros.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cube_case_polygon_triangulator_top import cct_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  cct_in_if.sink in_i,
  cct_out_if.source out_o
);

  logic       f_valid, f_ready;
  cct_item_t  f_item;
  logic       q_valid, q_ready;
  cct_item_t  q_item;
  logic [1:0] q_count;

  // Classification front end.
  cct_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_valid_o (f_valid),
    .item_ready_i (f_ready),
    .item_o       (f_item)
  );

  // Decoupling queue.
  cct_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_item_i  (f_item),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_item_o   (q_item),
    .count_o      (q_count)
  );

  // Walking and emitting back end.
  cct_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_ready_o (q_ready),
    .item_i       (q_item),
    .out_o        (out_o)
  );

  `CCT_ASSERT(a_empty_is_last, clk_i, rst_ni, (out_o.valid && out_o.is_empty) |-> out_o.last)
  `CCT_ASSERT(a_empty_zero, clk_i, rst_ni, (out_o.valid && out_o.is_empty) |-> (out_o.edge_first == 4'd0 && out_o.edge_cur == 4'd0))
  `CCT_ASSERT_NEVER(a_queue_over, clk_i, rst_ni, q_count > 2'(QueueDepth))
  `CCT_ASSERT(a_edge_range, clk_i, rst_ni, (out_o.valid && !out_o.is_empty) |-> (out_o.edge_first < 4'd12 && out_o.edge_prev < 4'd12 && out_o.edge_cur < 4'd12))

endmodule

// ===== test/tb_cube_case_polygon_triangulator_top.sv =====
// Testbench for the cube case polygon triangulator: drives corner-sign cubes,
// predicts the triangle stream of each and checks every output transaction.
// Depends on cct_pkg, cct_in_if, cct_out_if and the top level of the block.
`timescale 1ns / 1ps
module tb_cube_case_polygon_triangulator_top;
  import cct_pkg::*;

  typedef struct packed {
    logic [3:0] edge_first;
    logic [3:0] edge_prev;
    logic [3:0] edge_cur;
    logic       is_empty;
    logic       last;
  } tri_t;

  localparam int WatchdogLimit = 20000;

  // Cube geometry, held locally for the predictor.
  localparam logic [2:0] C1 [12] = '{3'd0, 3'd2, 3'd0, 3'd1, 3'd4, 3'd6,
                                     3'd4, 3'd5, 3'd0, 3'd1, 3'd2, 3'd3};
  localparam logic [2:0] C2 [12] = '{3'd1, 3'd3, 3'd2, 3'd3, 3'd5, 3'd7,
                                     3'd6, 3'd7, 3'd4, 3'd5, 3'd6, 3'd7};
  localparam logic [2:0] FL [12] = '{3'd2, 3'd0, 3'd0, 3'd5, 3'd1, 3'd3,
                                     3'd4, 3'd1, 3'd4, 3'd2, 3'd3, 3'd5};
  localparam logic [2:0] FR [12] = '{3'd0, 3'd3, 3'd4, 3'd0, 3'd2, 3'd1,
                                     3'd1, 3'd5, 3'd2, 3'd5, 3'd4, 3'd3};
  localparam logic [2:0] FCW [12] = '{3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1,
                                      3'd1, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3};
  localparam logic [3:0] ON [12] = '{4'd3, 4'd2, 4'd0, 4'd1, 4'd6, 4'd7,
                                     4'd5, 4'd4, 4'd4, 4'd0, 4'd1, 4'd5};
  localparam logic [3:0] OFF [12] = '{4'd8, 4'd11, 4'd10, 4'd9, 4'd9, 4'd10,
                                      4'd8, 4'd11, 4'd2, 4'd7, 4'd6, 4'd3};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  cct_in_if  in_ch ();
  cct_out_if out_ch ();

  cube_case_polygon_triangulator_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  always #1 clk_i = ~clk_i;

  tri_t tri_expected [$];
  int   n_errors = 0;
  int   idle_cycles = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  bit   hold_off = 1'b0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.corner_signs = 8'd0;
    out_ch.ready = 1'b0;
  end

  // Work out the triangles of one cube by walking its faces.
  task automatic predict_cube(input logic [7:0] signs);
    logic [3:0] poly [12][12];
    int         plen [12];
    bit         visited [12];
    logic [3:0] walk [12];
    int         npoly, n, cnt;
    logic [3:0] cur;
    logic [2:0] face;
    tri_t       t;
    npoly = 0;
    cnt = 0;
    for (int i = 0; i < 12; i++) begin
      visited[i] = 1'b0;
      plen[i] = 0;
    end
    for (int e = 0; e < 12; e++) begin
      if (visited[e] || signs[C1[e]] == signs[C2[e]] || npoly >= 12) continue;
      n = 0;
      cur = 4'(e);
      face = signs[C1[e]] ? FR[e] : FL[e];
      for (int s = 0; s < 64; s++) begin
        cur = (face == FCW[cur]) ? ON[cur] : OFF[cur];
        visited[cur] = 1'b1;
        if (signs[C1[cur]] != signs[C2[cur]]) begin
          if (n < 12) begin
            walk[n] = cur;
            n++;
          end
          if (cur == 4'(e)) break;
          face = (face == FL[cur]) ? FR[cur] : FL[cur];
        end
      end
      for (int i = 0; i < n; i++) poly[npoly][i] = walk[n - 1 - i];
      plen[npoly] = n;
      npoly++;
    end
    // Polygons come out newest first, each fanned from its first edge.
    for (int p = npoly - 1; p >= 0; p--) begin
      for (int i = 2; i < plen[p] && cnt < 10; i++) begin
        t = '{poly[p][0], poly[p][i - 1], poly[p][i], 1'b0, 1'b0};
        tri_expected.push_back(t);
        cnt++;
      end
    end
    if (cnt == 0) tri_expected.push_back('{4'd0, 4'd0, 4'd0, 1'b1, 1'b1});
    else tri_expected[$].last = 1'b1;
  endtask

  // Offer one cube and hold it until the transaction completes; the next
  // call or the drain takes valid down again.
  task automatic send_cube(input logic [7:0] signs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.corner_signs <= signs;
    predict_cube(signs);
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  // Receiver readiness, with an optional long hold-off.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each output transaction with the oldest expected triangle.
  always @(posedge clk_i) begin
    tri_t got, want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.edge_first, out_ch.edge_prev, out_ch.edge_cur,
              out_ch.is_empty, out_ch.last};
      if (tri_expected.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected triangle %p", got);
      end else begin
        want = tri_expected.pop_front();
        if (got !== want) begin
          n_errors++;
          if (n_errors <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("cube_case_polygon_triangulator_top test failed");
        $finish;
      end
    end
  end

  task automatic test_directed();
    logic [7:0] cubes [$];
    cubes = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'hFE, 8'h7F, 8'h03, 8'h0F, 8'h33,
              8'h55, 8'h69, 8'h96, 8'h81, 8'h18, 8'h24, 8'h42, 8'hA5, 8'h5A,
              8'h3C, 8'hC3, 8'h17, 8'hE8, 8'h66, 8'h99};
    foreach (cubes[i]) send_cube(cubes[i]);
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) send_cube(8'($urandom_range(255)));
  endtask

  // The receiver stalls while cubes keep coming, so the block backs up.
  task automatic test_backpressure();
    int held;
    hold_off = 1'b1;
    fork
      begin
        for (int i = 0; i < 6; i++) send_cube(8'($urandom_range(1, 254)));
      end
      begin
        held = 0;
        while (held < 300) begin
          @(posedge clk_i);
          held++;
        end
        hold_off = 1'b0;
      end
    join
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (tri_expected.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 23;
    recv_idle_pct = 86;
    test_directed();
    test_random(25);
    send_idle_pct = 86;
    recv_idle_pct = 23;
    test_random(25);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random(20);
    drain();
    repeat (100) @(posedge clk_i);
    if (n_errors == 0 && tri_expected.size() == 0) begin
      $display("cube_case_polygon_triangulator_top test passed");
    end else begin
      $display("cube_case_polygon_triangulator_top test failed");
    end
    $finish;
  end
endmodule
